>>> design/tvs_pkg.sv
// Package for the threshold value sorter: shared types and the order-key function.
// No dependencies; used by tvs_cell and threshold_value_sorter.
package tvs_pkg;

    localparam int WordWidth = 64;

    typedef logic [WordWidth-1:0] word_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EMIT
    } state_t;

    // Monotone unsigned key: key order matches double order, with -0 below +0.
    function automatic word_t order_key(input word_t bits);
        word_t key;
        if (bits[WordWidth-1])
        begin
            key = ~bits;
        end
        else
        begin
            key = bits ^ {1'b1, {(WordWidth-1){1'b0}}};
        end
        return key;
    endfunction

endpackage

>>> design/threshold_value_sorter.sv
// Top level of the threshold value sorter: a chain of insertion cells and its control.
// Depends on tvs_pkg and tvs_cell.
//
// The sorter takes one word per cycle while loading: a word is accepted when
// start is high and busy is low, and it drops straight into its ordered place
// in a row of CAPACITY cells, each of which either keeps its word, takes the
// new word, or takes its head-side neighbor's word in the same cycle. A word
// marked last is placed the same way, and from the next cycle on the chain
// shifts toward the head once per cycle, presenting one result word per cycle
// on sorted_value with strobe high, ascending, final_res on the last one and
// dropped on all of them if any word of the set found the chain full. Busy is
// high during emission, until every held word of the set has been presented. A
// last word always produces at least one result, since it is either stored or
// finds the chain already full. The receiver cannot stall: every result is
// valid for exactly one cycle.
module threshold_value_sorter
#(
    parameter int CAPACITY = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  tvs_pkg::word_t        value,
    input  logic                  last,
    output logic                  strobe,
    output tvs_pkg::word_t        sorted_value,
    output logic                  final_res,
    output logic                  dropped
);
    import tvs_pkg::*;

    localparam int CountWidth = $clog2(CAPACITY + 1);

    state_t state_reg;
    state_t state_next;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic overflow_reg;
    logic overflow_next;

    logic accept;
    logic full;
    logic do_insert;
    logic do_shift;

    logic  cell_valid  [CAPACITY];
    logic  cell_bigger [CAPACITY];
    word_t cell_word   [CAPACITY];

    assign accept    = start && !busy;
    assign full      = (count_reg == CountWidth'(CAPACITY));
    assign do_insert = accept && !full;
    assign do_shift  = (state_reg == ST_EMIT);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic  pv;
            logic  pb;
            word_t pw;
            logic  nv;
            word_t nw;
            if (g == 0)
            begin : g_head
                assign pv = 1'b1; // head cell always has room for the new word
                assign pb = 1'b0;
                assign pw = value;
            end
            else
            begin : g_body
                assign pv = cell_valid[g-1];
                assign pb = cell_bigger[g-1];
                assign pw = cell_word[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_tail
                assign nv = 1'b0;
                assign nw = cell_word[g];
            end
            else
            begin : g_mid
                assign nv = cell_valid[g+1];
                assign nw = cell_word[g+1];
            end
            tvs_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .insert     (do_insert),
                .shift_out  (do_shift),
                .clear      (1'b0),
                .new_word   (value),
                .prev_valid (pv),
                .prev_bigger(pb),
                .prev_word  (pw),
                .next_valid (nv),
                .next_word  (nw),
                .valid      (cell_valid[g]),
                .bigger     (cell_bigger[g]),
                .word       (cell_word[g])
            );
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (last)
                    begin
                        if (full || count_reg != '0)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_EMIT; // one word just inserted
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                count_next = count_reg - 1'b1;
                if (count_reg == CountWidth'(1))
                begin
                    state_next    = ST_LOAD;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        busy         = (state_reg == ST_EMIT);
        strobe       = (state_reg == ST_EMIT);
        sorted_value = cell_word[0];
        final_res    = (state_reg == ST_EMIT) && (count_reg == CountWidth'(1));
        dropped      = overflow_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The count never exceeds the chain length.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountWidth'(CAPACITY))
        else $error("held count above capacity");

    // Emission always presents a held word at the head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> cell_valid[0])
        else $error("emitting from an empty chain");

    // The final word of a set is followed by a return to loading with a clean flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && final_res) |=> (state_reg == ST_LOAD && !overflow_reg && count_reg == '0))
        else $error("set not cleared after final word");

    // Head cell is ordered below its neighbor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid[0] && cell_valid[1]) |->
            (order_key(cell_word[0]) <= order_key(cell_word[1])))
        else $error("chain out of order");
`endif

endmodule

>>> design/tvs_cell.sv
// One cell of the insertion chain: holds one word and its valid bit.
// Depends on tvs_pkg.
module tvs_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          insert,      // a new word enters the chain this cycle
    input  logic          shift_out,   // chain moves toward the output end
    input  logic          clear,       // drop all contents
    input  tvs_pkg::word_t new_word,
    input  logic          prev_valid,  // neighbor toward the head
    input  logic          prev_bigger, // neighbor holds a word with key above new_word
    input  tvs_pkg::word_t prev_word,
    input  logic          next_valid,  // neighbor toward the tail
    input  tvs_pkg::word_t next_word,
    output logic          valid,
    output logic          bigger,
    output tvs_pkg::word_t word
);
    import tvs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    word_t word_reg;
    word_t word_next;

    // Cells are kept sorted ascending from head (index 0). A cell whose word
    // is above the new word hands its word one place toward the tail.
    assign bigger = valid_reg && (order_key(word_reg) > order_key(new_word));

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (shift_out)
        begin
            valid_next = next_valid;
            word_next  = next_word;
        end
        else if (insert)
        begin
            if (prev_valid && prev_bigger)
            begin
                valid_next = 1'b1;
                word_next  = prev_word;
            end
            else if (bigger || !valid_reg)
            begin
                if (!valid_reg && !prev_valid)
                begin
                    valid_next = valid_reg; // beyond the end of the fill
                end
                else
                begin
                    valid_next = 1'b1;
                    word_next  = new_word;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule
